// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the decoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define MKD_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Check that one condition implies another in the same cycle
`define MKD_ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

// ----- hdl/mkd_pkg.sv -----
// Shared types, constants and code table of the Morse key decoder
package mkd_pkg;

	localparam int unsigned CFG_W      = 16;
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [CFG_W-1:0] DASH_THRESHOLD_RST = 16'd200;
	localparam logic [CFG_W-1:0] LETTER_GAP_RST     = 16'd1000;

	localparam int unsigned SYMBOLS_PER_MESSAGE_DEF = 16;

	// Register indexes (paddr bit 2)
	localparam logic REG_DASH_THRESHOLD = 1'b0;
	localparam logic REG_LETTER_GAP     = 1'b1;

	localparam int unsigned CODE_W = 5;
	localparam int unsigned LEN_W  = 3;
	localparam logic [LEN_W-1:0] CODE_MAX_LEN  = 3'd5;
	localparam logic [LEN_W-1:0] CODE_TOO_LONG = 3'd6;

	localparam logic [CFG_W-1:0] TIMER_MAX = 16'hFFFF;

	typedef logic [6:0] ascii_t;

	typedef struct packed {
		ascii_t letter;
		logic   letter_valid;
		logic   message_end;
	} result_t;

	// Letters by code: index = 2^length - 2 + code, first symbol as MSB, dash = 1
	localparam int unsigned TABLE_DEPTH = 62;
	localparam ascii_t CODE_TABLE [0:TABLE_DEPTH-1] = '{
		7'h45, 7'h54,
		7'h49, 7'h41, 7'h4E, 7'h4D,
		7'h53, 7'h55, 7'h52, 7'h57, 7'h44, 7'h4B, 7'h47, 7'h4F,
		7'h48, 7'h56, 7'h46, 7'h00, 7'h4C, 7'h00, 7'h50, 7'h4A,
		7'h42, 7'h58, 7'h43, 7'h59, 7'h5A, 7'h51, 7'h00, 7'h00,
		7'h35, 7'h34, 7'h00, 7'h33, 7'h00, 7'h00, 7'h00, 7'h32,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h31,
		7'h36, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h37, 7'h00, 7'h00, 7'h00, 7'h38, 7'h00, 7'h39, 7'h30
	};

	// Match a pending code; zero when the length is out of range or unknown
	function automatic ascii_t code_lookup(input logic [LEN_W-1:0] len,
			input logic [CODE_W-1:0] code);
		logic [5:0] idx;
		ascii_t     ch;
		ch  = '0;
		idx = (6'd1 << len) - 6'd2 + {1'b0, code};
		if (len >= 3'd1 && len <= CODE_MAX_LEN && idx < 6'(TABLE_DEPTH)) begin
			ch = CODE_TABLE[idx];
		end
		return ch;
	endfunction

endpackage

// ----- hdl/mkd_apb_regs.sv -----
// APB register bank holding the dash threshold and letter gap settings
module mkd_apb_regs
	import mkd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [CFG_W-1:0]      dash_threshold_ms,
	output logic [CFG_W-1:0]      letter_gap_ms
);

	logic [CFG_W-1:0] dash_threshold_q;
	logic [CFG_W-1:0] letter_gap_q;
	logic             wr_en;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[2];

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dash_threshold_q <= DASH_THRESHOLD_RST;
			letter_gap_q     <= LETTER_GAP_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_DASH_THRESHOLD: dash_threshold_q <= pwdata[CFG_W-1:0];
				REG_LETTER_GAP:     letter_gap_q     <= pwdata[CFG_W-1:0];
				default:            ;
			endcase
		end
	end

	// Read back the selected register
	always_comb begin
		unique case (reg_sel)
			REG_DASH_THRESHOLD: prdata = APB_DATA_W'(dash_threshold_q);
			REG_LETTER_GAP:     prdata = APB_DATA_W'(letter_gap_q);
			default:            prdata = '0;
		endcase
	end

	assign dash_threshold_ms = dash_threshold_q;
	assign letter_gap_ms     = letter_gap_q;

endmodule

// ----- hdl/morse_key_decoder_unit.sv -----
// Morse key decoder: key samples in, decoded letters and message ends out
//
// Takes one key level per millisecond tick (key_released: 0 pressed, 1 released) and
// times presses and gaps. A press shorter than dash_threshold_ms is a dot, else a dash; a
// press that follows a gap of at least letter_gap_ms adds a space, unless a space or message
// end came last; the space closes the pending letter. Codes of 1 to 5 symbols decode to
// A-Z or 0-9 as ASCII on letter; unknown codes give nothing. After SYMBOLS_PER_MESSAGE
// symbols the pending letter is flushed and a result with message_end set is always sent,
// letter_valid telling if a character came with it. Rate: one item per clock; each item
// updates the state and its result, if any, enters the result queue at the accepting edge
// and shows on the ports in the next cycle when the queue was empty. A two-entry result
// queue lets items keep flowing while a result waits; in_ready drops only when both entries
// are full. Configuration registers sit on the APB port at 0x0 (dash threshold) and 0x4
// (letter gap); they must be written while the block is idle; the block does not enforce it.
`include "assert_macros.svh"

module morse_key_decoder_unit
	import mkd_pkg::*;
#(
	parameter int unsigned SYMBOLS_PER_MESSAGE = SYMBOLS_PER_MESSAGE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  key_released,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [6:0]            letter,
	output logic                  letter_valid,
	output logic                  message_end
);

	localparam int unsigned CNT_W = $clog2(SYMBOLS_PER_MESSAGE + 1);

	logic [CFG_W-1:0] dash_threshold_ms;
	logic [CFG_W-1:0] letter_gap_ms;

	// Decoder state
	logic              key_was_released_q;
	logic [CFG_W-1:0]  press_timer_q;
	logic [CFG_W-1:0]  gap_timer_q;
	logic [CODE_W-1:0] code_symbols_q;
	logic [LEN_W-1:0]  code_length_q;
	logic              last_was_space_q;
	logic [CNT_W-1:0]  symbol_count_q;

	// Next state
	logic [CFG_W-1:0]  press_timer_d;
	logic [CFG_W-1:0]  gap_timer_d;
	logic [CODE_W-1:0] code_symbols_d;
	logic [LEN_W-1:0]  code_length_d;
	logic              last_was_space_d;
	logic [CNT_W-1:0]  symbol_count_d;

	logic              have_symbol;
	logic              is_space;
	logic              is_dash;
	logic [CODE_W-1:0] code_added;
	logic [LEN_W-1:0]  len_added;
	logic [CNT_W-1:0]  count_inc;
	logic              msg_end;
	logic              take;
	ascii_t            ch;
	logic              has_result;
	result_t           res_new;

	// Result queue: head entry drives the ports, second entry absorbs a stall
	result_t res0_q;
	result_t res1_q;
	logic    res0_valid_q;
	logic    res1_valid_q;
	logic    in_acc;
	logic    push;
	logic    pop;

	mkd_apb_regs u_regs (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.dash_threshold_ms (dash_threshold_ms),
		.letter_gap_ms     (letter_gap_ms)
	);

	// Time presses and gaps, detect symbol edges
	always_comb begin
		press_timer_d = press_timer_q;
		gap_timer_d   = gap_timer_q;
		have_symbol   = 1'b0;
		is_space      = 1'b0;
		is_dash       = 1'b0;
		if (!key_released) begin
			if (key_was_released_q) begin
				press_timer_d = 16'd1;
				is_space      = !last_was_space_q && (gap_timer_q >= letter_gap_ms);
				have_symbol   = is_space;
			end else if (press_timer_q != TIMER_MAX) begin
				press_timer_d = press_timer_q + 16'd1;
			end
		end else begin
			if (!key_was_released_q) begin
				have_symbol = 1'b1;
				is_dash     = press_timer_q >= dash_threshold_ms;
				gap_timer_d = 16'd1;
			end else if (gap_timer_q != TIMER_MAX) begin
				gap_timer_d = gap_timer_q + 16'd1;
			end
		end
	end

	// Append a dot or dash to the pending code; past five symbols mark it too long
	always_comb begin
		if (code_length_q < CODE_MAX_LEN) begin
			code_added = {code_symbols_q[CODE_W-2:0], is_dash};
			len_added  = code_length_q + 3'd1;
		end else begin
			code_added = code_symbols_q;
			len_added  = CODE_TOO_LONG;
		end
	end

	assign count_inc = symbol_count_q + CNT_W'(1);
	assign msg_end   = have_symbol && (count_inc == CNT_W'(SYMBOLS_PER_MESSAGE));
	assign take      = is_space || msg_end;
	assign ch        = take ? (is_space ? code_lookup(code_length_q, code_symbols_q)
	                                    : code_lookup(len_added, code_added)) : '0;

	// Update code, symbol count and space flag
	always_comb begin
		code_symbols_d   = code_symbols_q;
		code_length_d    = code_length_q;
		last_was_space_d = last_was_space_q;
		symbol_count_d   = symbol_count_q;
		if (have_symbol) begin
			symbol_count_d = count_inc;
			if (!is_space) begin
				code_symbols_d   = code_added;
				code_length_d    = len_added;
				last_was_space_d = 1'b0;
			end else begin
				last_was_space_d = 1'b1;
			end
			if (take) begin
				code_symbols_d = '0;
				code_length_d  = '0;
			end
			if (msg_end) begin
				symbol_count_d   = '0;
				last_was_space_d = 1'b1;
			end
		end
	end

	assign has_result           = have_symbol && ((ch != '0) || msg_end);
	assign res_new.letter       = ch;
	assign res_new.letter_valid = (ch != '0);
	assign res_new.message_end  = msg_end;

	assign in_ready = !res1_valid_q;
	assign in_acc   = in_valid && in_ready;
	assign push     = in_acc && has_result;
	assign pop      = res0_valid_q && out_ready;

	// Hold decoder state; advance on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_was_released_q <= 1'b1;
			press_timer_q      <= '0;
			gap_timer_q        <= '0;
			code_symbols_q     <= '0;
			code_length_q      <= '0;
			last_was_space_q   <= 1'b1;
			symbol_count_q     <= '0;
		end else if (in_acc) begin
			key_was_released_q <= key_released;
			press_timer_q      <= press_timer_d;
			gap_timer_q        <= gap_timer_d;
			code_symbols_q     <= code_symbols_d;
			code_length_q      <= code_length_d;
			last_was_space_q   <= last_was_space_d;
			symbol_count_q     <= symbol_count_d;
		end
	end

	// Queue valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res0_valid_q <= 1'b0;
			res1_valid_q <= 1'b0;
		end else begin
			priority if (push && pop) begin
				res0_valid_q <= 1'b1;
			end else if (push) begin
				res0_valid_q <= 1'b1;
				res1_valid_q <= res0_valid_q;
			end else if (pop) begin
				res0_valid_q <= res1_valid_q;
				res1_valid_q <= 1'b0;
			end
		end
	end

	// Queue payload
	always_ff @(posedge clk) begin
		priority if (push && pop) begin
			if (res1_valid_q) begin
				res0_q <= res1_q;
				res1_q <= res_new;
			end else begin
				res0_q <= res_new;
			end
		end else if (push) begin
			if (res0_valid_q) begin
				res1_q <= res_new;
			end else begin
				res0_q <= res_new;
			end
		end else if (pop) begin
			res0_q <= res1_q;
		end
	end

	assign out_valid    = res0_valid_q;
	assign letter       = res0_q.letter;
	assign letter_valid = res0_q.letter_valid;
	assign message_end  = res0_q.message_end;

	// Checks
	`MKD_ASSERT_IMPLY(a_queue_order, res1_valid_q, res0_valid_q, "second entry without head")
	`MKD_ASSERT_IMPLY(a_empty_result_ends, out_valid && !letter_valid, message_end, "no message end")
	`MKD_ASSERT_IMPLY(a_letter_nonzero, out_valid && letter_valid, letter != '0, "valid letter is zero")
	`MKD_ASSERT_ALWAYS(a_count_range, symbol_count_q < CNT_W'(SYMBOLS_PER_MESSAGE), "count overflow")

endmodule

// ----- test/tb_morse_key_decoder_unit.sv -----
// Self-checking testbench for the Morse key decoder unit
`timescale 1ns / 100ps

module tb_morse_key_decoder_unit;
	import mkd_pkg::*;

	localparam int RESET_CYCLES  = 5;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 5000;

	localparam bit KEY_PRESSED  = 1'b0;
	localparam bit KEY_RELEASED = 1'b1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  key_released = 1'b1;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [6:0]            letter;
	logic                  letter_valid;
	logic                  message_end;

	// Key samples waiting to be sent, decoded letters waiting to come out
	bit      key_samples [$];
	result_t pending_letters [$];
	int      failures = 0;

	// Timing registers as last written
	logic [CFG_W-1:0] dash_cfg = DASH_THRESHOLD_RST;
	logic [CFG_W-1:0] gap_cfg  = LETTER_GAP_RST;

	// Decoder state mirror
	logic             key_up = 1'b1;
	logic [CFG_W-1:0] press_ms = '0;
	logic [CFG_W-1:0] gap_ms = '0;
	logic [CODE_W-1:0] code_bits = '0;
	logic [LEN_W-1:0] code_len = '0;
	logic             after_space = 1'b1;
	logic [4:0]       symbol_cnt = '0;

	// Handshake pacing
	int  send_gap = 0;
	int  send_calm = 0;
	int  recv_stall = 0;
	int  recv_calm = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	logic hold_request = 1'b0;
	logic rx_holding = 1'b0;
	int  quiet_cycles = 0;

	morse_key_decoder_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.key_released (key_released),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.letter       (letter),
		.letter_valid (letter_valid),
		.message_end  (message_end)
	);

	initial forever #2 clk = ~clk;

	// Map a dot/dash code (first symbol as MSB, dash = 1) to its character
	function automatic logic [7:0] morse_char(input logic [LEN_W-1:0] len,
			input logic [CODE_W-1:0] code);
		case ({len, code})
			{3'd1, 5'b00000}: return "E";
			{3'd1, 5'b00001}: return "T";
			{3'd2, 5'b00000}: return "I";
			{3'd2, 5'b00001}: return "A";
			{3'd2, 5'b00010}: return "N";
			{3'd2, 5'b00011}: return "M";
			{3'd3, 5'b00000}: return "S";
			{3'd3, 5'b00001}: return "U";
			{3'd3, 5'b00010}: return "R";
			{3'd3, 5'b00011}: return "W";
			{3'd3, 5'b00100}: return "D";
			{3'd3, 5'b00101}: return "K";
			{3'd3, 5'b00110}: return "G";
			{3'd3, 5'b00111}: return "O";
			{3'd4, 5'b00000}: return "H";
			{3'd4, 5'b00001}: return "V";
			{3'd4, 5'b00010}: return "F";
			{3'd4, 5'b00100}: return "L";
			{3'd4, 5'b00110}: return "P";
			{3'd4, 5'b00111}: return "J";
			{3'd4, 5'b01000}: return "B";
			{3'd4, 5'b01001}: return "X";
			{3'd4, 5'b01010}: return "C";
			{3'd4, 5'b01011}: return "Y";
			{3'd4, 5'b01100}: return "Z";
			{3'd4, 5'b01101}: return "Q";
			{3'd5, 5'b00000}: return "5";
			{3'd5, 5'b00001}: return "4";
			{3'd5, 5'b00011}: return "3";
			{3'd5, 5'b00111}: return "2";
			{3'd5, 5'b01111}: return "1";
			{3'd5, 5'b10000}: return "6";
			{3'd5, 5'b11000}: return "7";
			{3'd5, 5'b11100}: return "8";
			{3'd5, 5'b11110}: return "9";
			{3'd5, 5'b11111}: return "0";
			default:          return 8'h00;
		endcase
	endfunction

	// Advance the decoder mirror by one key sample and queue the letter it yields
	task automatic decode_key_sample(input logic released);
		logic       have_symbol;
		logic       is_space;
		logic       is_dash;
		logic       msg_end;
		logic [7:0] ch;
		result_t    item;
		have_symbol = 1'b0;
		is_space    = 1'b0;
		is_dash     = 1'b0;
		ch          = 8'h00;
		if (released == KEY_PRESSED) begin
			if (key_up) begin
				press_ms = 16'd1;
				if (!after_space && gap_ms >= gap_cfg) begin
					have_symbol = 1'b1;
					is_space    = 1'b1;
				end
			end else if (press_ms != TIMER_MAX) begin
				press_ms = press_ms + 16'd1;
			end
			key_up = 1'b0;
		end else begin
			if (!key_up) begin
				have_symbol = 1'b1;
				is_dash     = (press_ms >= dash_cfg);
				gap_ms      = 16'd1;
			end else if (gap_ms != TIMER_MAX) begin
				gap_ms = gap_ms + 16'd1;
			end
			key_up = 1'b1;
		end
		if (!have_symbol)
			return;

		symbol_cnt = symbol_cnt + 5'd1;
		// append the symbol; past five symbols the code is marked too long
		if (!is_space) begin
			if (code_len < CODE_MAX_LEN) begin
				code_bits = {code_bits[CODE_W-2:0], is_dash};
				code_len  = code_len + 3'd1;
			end else begin
				code_len = CODE_TOO_LONG;
			end
		end
		after_space = is_space;
		msg_end     = (symbol_cnt >= SYMBOLS_PER_MESSAGE_DEF);

		// close the pending letter on a space or at the end of a message
		if (is_space || msg_end) begin
			ch        = morse_char(code_len, code_bits);
			code_len  = '0;
			code_bits = '0;
		end
		if (msg_end) begin
			symbol_cnt  = '0;
			after_space = 1'b1;
		end
		if (ch != 8'h00 || msg_end) begin
			item.letter       = ch[6:0];
			item.letter_valid = (ch != 8'h00);
			item.message_end  = msg_end;
			pending_letters.push_back(item);
		end
	endtask

	// Pick an idle length: mostly none, some short, a few long, with calm stretches
	function automatic int idle_length(inout int calm);
		int roll;
		if (calm != 0) begin
			calm--;
			return 0;
		end
		roll = $urandom_range(0, 199);
		if (roll == 0) begin
			calm = $urandom_range(30, 150);
			return 0;
		end
		if (roll < 140)
			return 0;
		if (roll < 184)
			return $urandom_range(1, 3);
		if (roll < 196)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Press and release lengths around the current thresholds
	function automatic int dot_ms();
		return (dash_cfg > 16'd1) ? int'($urandom_range(1, dash_cfg - 16'd1)) : 1;
	endfunction

	function automatic int dash_ms();
		int lo;
		lo = (dash_cfg == '0) ? 1 : int'(dash_cfg);
		return $urandom_range(lo, lo + 2);
	endfunction

	function automatic int pause_ms();
		return (gap_cfg > 16'd1) ? int'($urandom_range(1, gap_cfg - 16'd1)) : 1;
	endfunction

	function automatic int space_ms();
		int lo;
		lo = (gap_cfg == '0) ? 1 : int'(gap_cfg);
		return $urandom_range(lo, lo + 2);
	endfunction

	task automatic push_run(input bit level, input int len);
		repeat (len) key_samples.push_back(level);
	endtask

	// Key one symbol, then pause within the letter or long enough to end it
	task automatic push_symbol(input bit is_dash, input bit closes_letter);
		push_run(KEY_PRESSED, is_dash ? dash_ms() : dot_ms());
		push_run(KEY_RELEASED, closes_letter ? space_ms() : pause_ms());
	endtask

	// Key a text of dots and dashes, letters split by blanks
	task automatic push_morse(input string text);
		int i;
		for (i = 0; i < text.len(); i++) begin
			if (text[i] != " ")
				push_symbol(text[i] == "-", i == text.len() - 1 || text[i + 1] == " ");
		end
	endtask

	// Mostly well-formed letters with random codes and timing, some raw noise
	task automatic push_random_keying(input int count);
		int goal;
		int len;
		int k;
		goal = key_samples.size() + count;
		while (key_samples.size() < goal) begin
			if ($urandom_range(0, 9) < 8) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(1, 5);
				for (k = 0; k < len; k++)
					push_symbol($urandom_range(0, 1), k == len - 1);
			end else begin
				push_run($urandom_range(0, 1),
					$urandom_range(1, 2 * (int'(dash_cfg) + int'(gap_cfg)) + 3));
			end
		end
	endtask

	// Write one register: setup cycle, then access cycle
	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {{(APB_DATA_W - CFG_W){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Read one register back and compare it with the expected value
	task automatic check_reg(input logic idx, input logic [CFG_W-1:0] want, input string name);
		logic [APB_DATA_W-1:0] got;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== {{(APB_DATA_W - CFG_W){1'b0}}, want}) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	task automatic write_timing(input logic [CFG_W-1:0] dash, input logic [CFG_W-1:0] gap);
		write_reg(REG_DASH_THRESHOLD, dash);
		write_reg(REG_LETTER_GAP, gap);
		dash_cfg = dash;
		gap_cfg  = gap;
	endtask

	// Wait until every item is sent and every letter is out, then let the block settle
	task automatic wait_idle();
		while (key_samples.size() != 0 || in_valid || pending_letters.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Stimulus sequence
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// reset values of both timing registers
		check_reg(REG_DASH_THRESHOLD, DASH_THRESHOLD_RST, "dash_threshold_ms");
		check_reg(REG_LETTER_GAP, LETTER_GAP_RST, "letter_gap_ms");

		// reset timing: a press just under and one at the dash threshold; the
		// pending code comes out at the first space of the next phase
		push_run(KEY_PRESSED, 199);
		push_run(KEY_RELEASED, 3);
		push_run(KEY_PRESSED, 200);
		push_run(KEY_RELEASED, 5);
		wait_idle();

		// known letters and digits, an unknown code, a too-long code
		write_timing(16'd3, 16'd4);
		push_morse("... --- ..... ----- .---- - . ..-- ......");
		push_random_keying(150);
		wait_idle();

		write_timing(16'd1, 16'd1);
		push_random_keying(100);
		wait_idle();

		// zero thresholds: every press a dash, every allowed press a space
		write_timing(16'd0, 16'd0);
		push_random_keying(80);
		wait_idle();

		// top thresholds: every press a dot, no gap long enough for a space
		write_timing(TIMER_MAX, TIMER_MAX);
		push_run(KEY_PRESSED, 3);
		push_run(KEY_RELEASED, 2);
		push_run(KEY_PRESSED, 2);
		push_run(KEY_RELEASED, 1);
		wait_idle();

		// busy traffic with one long output hold-off
		write_timing(16'($urandom_range(2, 6)), 16'($urandom_range(2, 8)));
		push_random_keying(200);
		hold_request <= 1'b1;
		wait_idle();

		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Driver: send queued key samples, idling between items at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else if (!in_valid || in_ready) begin
			if (send_gap != 0 && !rx_holding) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (key_samples.size() != 0) begin
				key_released <= key_samples.pop_front();
				in_valid     <= 1'b1;
				send_gap = idle_length(send_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall at random, and hold off once for a long stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			rx_holding <= 1'b0;
		end else begin
			if (hold_request && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (recv_stall != 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				recv_stall = idle_length(recv_calm);
			end
			rx_holding <= (hold_left != 0);
		end
	end

	// Monitor: check each result against the oldest decoded letter, then predict
	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_letters.size() == 0) begin
					$error("unexpected result: letter 'h%02h letter_valid %0b message_end %0b",
						letter, letter_valid, message_end);
					failures++;
				end else begin
					want = pending_letters.pop_front();
					if (letter !== want.letter) begin
						$error("letter: expected 'h%02h, got 'h%02h", want.letter, letter);
						failures++;
					end
					if (letter_valid !== want.letter_valid) begin
						$error("letter_valid: expected %0b, got %0b",
							want.letter_valid, letter_valid);
						failures++;
					end
					if (message_end !== want.message_end) begin
						$error("message_end: expected %0b, got %0b",
							want.message_end, message_end);
						failures++;
					end
				end
			end
			if (in_valid && in_ready)
				decode_key_sample(key_released);
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

endmodule
